[hw/rtl/gcc_pkg.sv]
// shared types, widths and constants of the greenhouse climate controller
package gcc_pkg;

	localparam int TEMP_W     = 12;
	localparam int HUM_W      = 10;
	localparam int LIGHT_W    = 16;
	localparam int TIME_W     = 32;
	localparam int HOURS_W    = 5;
	localparam int DRIVE_W    = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int HOUR_TICKS_DEF  = 3600000;
	localparam int MAX_LEVEL_DEF   = 100;
	localparam int RESET_HOURS     = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE       = 3'd0,
		REG_TEMP_SP      = 3'd1,
		REG_HUM_SP       = 3'd2,
		REG_LIGHT_TARGET = 3'd3,
		REG_CYCLE_HOURS  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_setpoint;
		logic        [HUM_W-1:0]  humidity_setpoint;
	} clim_cfg_t;

	typedef struct packed {
		logic heater_on;
		logic fan_on;
	} clim_out_t;

	typedef struct packed {
		logic               lamp_on;
		logic [DRIVE_W-1:0] lamp_drive;
	} lamp_out_t;

endpackage

[hw/rtl/greenhouse_climate_controller.sv]
// greenhouse climate controller top level: configuration, input stage and result handshake
//
// Each transaction on the input channel is one control step. It is held in an input
// register, and the heater, fan and lamp state registers, which are the result
// register, update from it as it advances, so a result passes the input register
// and then the state registers. One step is taken every cycle while the output does
// not stall; the rate is set by the state update (hysteresis compares, lamp level
// step and the elapsed-time subtract and compare). The lamp toggle threshold is multiplied
// out when the cycle-hours register is written. With the enable bit low the state holds and
// each step repeats the held outputs. An output stall backs up through the input register.
module greenhouse_climate_controller #(
	parameter int HOUR_TICKS = gcc_pkg::HOUR_TICKS_DEF,
	parameter int MAX_LEVEL  = gcc_pkg::MAX_LEVEL_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [gcc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gcc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [gcc_pkg::TEMP_W-1:0]   temp_reading,
	input  logic        [gcc_pkg::HUM_W-1:0]    humidity_reading,
	input  logic        [gcc_pkg::LIGHT_W-1:0]  light_reading,
	input  logic        [gcc_pkg::TIME_W-1:0]   now_ms,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                heater_on,
	output logic                                fan_on,
	output logic                                lamp_on,
	output logic [gcc_pkg::DRIVE_W-1:0]         lamp_drive
);

	logic                                enable_q;
	gcc_pkg::clim_cfg_t                  clim_cfg_q;
	logic [gcc_pkg::LIGHT_W-1:0]         light_target_q;
	logic                                hours_we;

	logic                                valid_s1;
	logic signed [gcc_pkg::TEMP_W-1:0]   temp_s1;
	logic        [gcc_pkg::HUM_W-1:0]    hum_s1;
	logic        [gcc_pkg::LIGHT_W-1:0]  light_s1;
	logic        [gcc_pkg::TIME_W-1:0]   now_s1;

	logic                                out_valid_q;
	logic                                out_ready;
	logic                                advance;
	logic                                step;

	gcc_pkg::clim_out_t                  clim_status;
	gcc_pkg::lamp_out_t                  lamp_status;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q                     <= 1'b0;
			clim_cfg_q.temp_setpoint     <= '0;
			clim_cfg_q.humidity_setpoint <= '0;
			light_target_q               <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				gcc_pkg::REG_ENABLE: begin
					enable_q <= cfg_data[0];
				end
				gcc_pkg::REG_TEMP_SP: begin
					clim_cfg_q.temp_setpoint <= cfg_data[gcc_pkg::TEMP_W-1:0];
				end
				gcc_pkg::REG_HUM_SP: begin
					clim_cfg_q.humidity_setpoint <= cfg_data[gcc_pkg::HUM_W-1:0];
				end
				gcc_pkg::REG_LIGHT_TARGET: begin
					light_target_q <= cfg_data[gcc_pkg::LIGHT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign hours_we = cfg_wr_en && (cfg_index == gcc_pkg::REG_CYCLE_HOURS);

	// handshake
	assign out_ready = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;
	assign step      = advance && enable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_ready) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			temp_s1  <= temp_reading;
			hum_s1   <= humidity_reading;
			light_s1 <= light_reading;
			now_s1   <= now_ms;
		end
	end

	gcc_climate u_climate (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (clim_cfg_q),
		.temp   (temp_s1),
		.hum    (hum_s1),
		.status (clim_status)
	);

	gcc_lamp #(
		.HOUR_TICKS (HOUR_TICKS),
		.MAX_LEVEL  (MAX_LEVEL)
	) u_lamp (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.hours_we     (hours_we),
		.hours        (cfg_data[gcc_pkg::HOURS_W-1:0]),
		.light_target (light_target_q),
		.light        (light_s1),
		.now          (now_s1),
		.status       (lamp_status)
	);

	assign out_valid  = out_valid_q;
	assign heater_on  = clim_status.heater_on;
	assign fan_on     = clim_status.fan_on;
	assign lamp_on    = lamp_status.lamp_on;
	assign lamp_drive = lamp_status.lamp_drive;

endmodule

[hw/rtl/gcc_climate.sv]
// heater and fan hysteresis state
module gcc_climate (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  gcc_pkg::clim_cfg_t                cfg,
	input  logic signed [gcc_pkg::TEMP_W-1:0] temp,
	input  logic        [gcc_pkg::HUM_W-1:0]  hum,
	output gcc_pkg::clim_out_t                status
);

	logic heater_q;
	logic fan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heater_q <= 1'b0;
			fan_q    <= 1'b0;
		end else if (step) begin
			if (temp < cfg.temp_setpoint) begin
				heater_q <= 1'b1;
			end else if (temp > cfg.temp_setpoint) begin
				heater_q <= 1'b0;
			end
			if (hum > cfg.humidity_setpoint) begin
				fan_q <= 1'b1;
			end else if (hum < cfg.humidity_setpoint) begin
				fan_q <= 1'b0;
			end
		end
	end

	assign status.heater_on = heater_q;
	assign status.fan_on    = fan_q;

endmodule

[hw/rtl/gcc_lamp.sv]
// lamp light cycle timer and level regulation
module gcc_lamp #(
	parameter int HOUR_TICKS = gcc_pkg::HOUR_TICKS_DEF,
	parameter int MAX_LEVEL  = gcc_pkg::MAX_LEVEL_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic                           hours_we,
	input  logic [gcc_pkg::HOURS_W-1:0]    hours,
	input  logic [gcc_pkg::LIGHT_W-1:0]    light_target,
	input  logic [gcc_pkg::LIGHT_W-1:0]    light,
	input  logic [gcc_pkg::TIME_W-1:0]     now,
	output gcc_pkg::lamp_out_t             status
);

	localparam int LVL_W   = $clog2(MAX_LEVEL + 1);
	localparam int LIM_MAX = (2 ** gcc_pkg::HOURS_W - 1) * HOUR_TICKS;
	localparam int LIM_W   = $clog2(LIM_MAX + 1);
	localparam logic [LIM_W-1:0] LIM_RST = LIM_W'(gcc_pkg::RESET_HOURS * HOUR_TICKS);
	localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAX_LEVEL);

	logic                           phase_q;
	logic [LVL_W-1:0]               level_q;
	logic [gcc_pkg::TIME_W-1:0]     last_q;
	logic [gcc_pkg::DRIVE_W-1:0]    drive_q;
	logic [LIM_W-1:0]               limit_q;

	logic [gcc_pkg::TIME_W-1:0]     elapsed;
	logic                           toggle;
	logic                           phase_n;
	logic [LVL_W-1:0]               level_n;

	// threshold product is formed once per write of the cycle length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIM_RST;
		end else if (hours_we) begin
			limit_q <= LIM_W'(LIM_W'(hours) * LIM_W'(HOUR_TICKS));
		end
	end

	always_comb begin
		level_n = level_q;
		if (phase_q) begin
			if (light < light_target) begin
				level_n = (level_q < LVL_MAX) ? level_q + LVL_W'(1) : LVL_MAX;
			end else if (light > light_target) begin
				if (level_q != '0) begin
					level_n = level_q - LVL_W'(1);
				end
			end
		end
		elapsed = now - last_q;
		toggle  = elapsed >= gcc_pkg::TIME_W'(limit_q);
		phase_n = phase_q ^ toggle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			level_q <= '0;
			last_q  <= '0;
			drive_q <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			level_q <= level_n;
			if (toggle) begin
				last_q <= now;
			end
			drive_q <= (phase_n && !toggle) ? gcc_pkg::DRIVE_W'(level_n) : '0;
		end
	end

	assign status.lamp_on    = phase_q;
	assign status.lamp_drive = drive_q;

endmodule

[tb/testbench.sv]
// self-checking testbench for greenhouse_climate_controller: directed and random control steps
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import gcc_pkg::*;

	localparam int HOUR_MS = HOUR_TICKS_DEF;
	localparam int LEVEL_CAP = MAX_LEVEL_DEF;
	localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG = REG_CYCLE_HOURS + 1;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_STEPS = 112;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_AFTER = 400;
	localparam int HOLD_CYCLES = 200;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp;
		logic [HUM_W-1:0] hum;
		logic [LIGHT_W-1:0] light;
		logic [TIME_W-1:0] stamp;
	} sensor_step_t;

	typedef struct packed {
		logic heater;
		logic fan;
		logic lamp;
		logic [DRIVE_W-1:0] drive;
	} actuator_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [TEMP_W-1:0] temp_reading = '0;
	logic [HUM_W-1:0] humidity_reading = '0;
	logic [LIGHT_W-1:0] light_reading = '0;
	logic [TIME_W-1:0] now_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic heater_on;
	logic fan_on;
	logic lamp_on;
	logic [DRIVE_W-1:0] lamp_drive;

	// controller settings as last written
	logic run_enable = 1'b0;
	logic signed [TEMP_W-1:0] temp_target = '0;
	logic [HUM_W-1:0] hum_target = '0;
	logic [LIGHT_W-1:0] light_goal = '0;
	logic [HOURS_W-1:0] cycle_hours = HOURS_W'(RESET_HOURS);

	// predicted controller state
	logic heater_st = 1'b0;
	logic fan_st = 1'b0;
	logic lamp_st = 1'b0;
	int lamp_lvl = 0;
	logic [TIME_W-1:0] last_toggle = '0;
	logic [DRIVE_W-1:0] drive_held = '0;

	sensor_step_t pending_steps[$];
	actuator_set_t expected_actuators[$];
	sensor_step_t offered_step;
	int steps_taken = 0;
	int mismatches = 0;
	int sender_idle_pct = 19;
	int receiver_idle_pct = 77;
	int light_low_pct = 50;
	int hold_left = 0;
	logic hold_done = 1'b0;

	// stimulus steering: timestamp cursor and a rough copy of the toggle mark
	logic [TIME_W-1:0] clock_ms = '0;
	logic [TIME_W-1:0] steer_mark = '0;

	greenhouse_climate_controller uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.temp_reading(temp_reading),
		.humidity_reading(humidity_reading),
		.light_reading(light_reading),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.heater_on(heater_on),
		.fan_on(fan_on),
		.lamp_on(lamp_on),
		.lamp_drive(lamp_drive)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("testbench: FAIL");
		$finish;
	end

	function automatic void clear_controller();
		heater_st = 1'b0;
		fan_st = 1'b0;
		lamp_st = 1'b0;
		lamp_lvl = 0;
		last_toggle = '0;
		drive_held = '0;
	endfunction

	function automatic actuator_set_t advance_controller(input sensor_step_t s);
		actuator_set_t r;
		logic toggled;
		logic [TIME_W-1:0] elapsed;
		longint unsigned threshold;
		if (run_enable) begin
			toggled = 1'b0;
			if (s.temp < temp_target)
				heater_st = 1'b1;
			else if (s.temp > temp_target)
				heater_st = 1'b0;
			if (s.hum > hum_target)
				fan_st = 1'b1;
			else if (s.hum < hum_target)
				fan_st = 1'b0;
			// level moves with the phase from before any toggle
			if (lamp_st) begin
				if (s.light < light_goal)
					lamp_lvl = (lamp_lvl < LEVEL_CAP) ? lamp_lvl + 1 : LEVEL_CAP;
				else if (s.light > light_goal && lamp_lvl > 0)
					lamp_lvl = lamp_lvl - 1;
			end
			elapsed = s.stamp - last_toggle;
			threshold = longint'(cycle_hours) * HOUR_MS;
			if (elapsed >= threshold) begin
				last_toggle = s.stamp;
				lamp_st = ~lamp_st;
				toggled = 1'b1;
			end
			drive_held = (lamp_st && !toggled) ? DRIVE_W'(lamp_lvl) : '0;
		end
		r.heater = heater_st;
		r.fan = fan_st;
		r.lamp = lamp_st;
		r.drive = drive_held;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : driver
		sensor_step_t next_step;
		if (!arst_n) begin
			in_valid <= 1'b0;
			clear_controller();
		end else begin
			if (in_valid && !in_stall) begin
				expected_actuators.push_back(advance_controller(offered_step));
				steps_taken <= steps_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (pending_steps.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					next_step = pending_steps.pop_front();
					offered_step <= next_step;
					temp_reading <= next_step.temp;
					humidity_reading <= next_step.hum;
					light_reading <= next_step.light;
					now_ms <= next_step.stamp;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : receiver
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
		end else begin
			// one long hold-off so the input side backs up
			if (!hold_done && steps_taken >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				hold_left = hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < receiver_idle_pct);
			end
		end
	end

	function automatic void compare_field(input string field, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : monitor
		actuator_set_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_actuators.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, got heater %0b fan %0b lamp %0b drive %0d",
					$time, heater_on, fan_on, lamp_on, lamp_drive);
				mismatches++;
			end else begin
				want = expected_actuators.pop_front();
				compare_field("heater_on", want.heater, heater_on);
				compare_field("fan_on", want.fan, fan_on);
				compare_field("lamp_on", want.lamp, lamp_on);
				compare_field("lamp_drive", want.drive, lamp_drive);
			end
		end
	end

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			REG_ENABLE: run_enable = data[0];
			REG_TEMP_SP: temp_target = data[TEMP_W-1:0];
			REG_HUM_SP: hum_target = data[HUM_W-1:0];
			REG_LIGHT_TARGET: light_goal = data[LIGHT_W-1:0];
			REG_CYCLE_HOURS: cycle_hours = data[HOURS_W-1:0];
			default: ;
		endcase
	endtask

	// unused upper data bits carry noise
	task automatic apply_settings(input logic en, input logic signed [TEMP_W-1:0] tsp,
			input logic [HUM_W-1:0] hsp, input logic [LIGHT_W-1:0] tgt, input logic [HOURS_W-1:0] hrs);
		logic [31:0] noise;
		logic [CFG_IDX_W-1:0] spare;
		noise = $urandom;
		spare = FIRST_SPARE_REG + CFG_IDX_W'($urandom_range(2));
		write_register(REG_ENABLE, {noise[14:0], en});
		write_register(REG_TEMP_SP, {noise[3:0], tsp});
		write_register(REG_HUM_SP, {noise[21:16], hsp});
		write_register(REG_LIGHT_TARGET, tgt);
		write_register(REG_CYCLE_HOURS, {noise[31:21], hrs});
		write_register(spare, noise[CFG_DATA_W-1:0] ^ noise[31:16]);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_steps.size() != 0 || in_valid || expected_actuators.size() != 0)
			@(posedge clk);
	endtask

	function automatic void offer(input logic signed [TEMP_W-1:0] t, input logic [HUM_W-1:0] h,
			input logic [LIGHT_W-1:0] l, input logic [TIME_W-1:0] stamp);
		sensor_step_t s;
		logic [TIME_W-1:0] gap;
		s.temp = t;
		s.hum = h;
		s.light = l;
		s.stamp = stamp;
		pending_steps.push_back(s);
		clock_ms = stamp;
		gap = stamp - steer_mark;
		if (run_enable && longint'(gap) >= longint'(cycle_hours) * HOUR_MS)
			steer_mark = stamp;
	endfunction

	function automatic void offer_random();
		logic signed [TEMP_W-1:0] t;
		logic [HUM_W-1:0] h;
		logic [LIGHT_W-1:0] l;
		logic [TIME_W-1:0] stamp;
		int unsigned roll;
		int unsigned span;
		span = int'(cycle_hours) * HOUR_MS;
		t = ($urandom_range(99) < 20) ? TEMP_W'($urandom) : TEMP_W'(temp_target + $urandom_range(6) - 3);
		h = ($urandom_range(99) < 20) ? HUM_W'($urandom) : HUM_W'(hum_target + $urandom_range(4) - 2);
		roll = $urandom_range(99);
		if (roll < 8)
			l = LIGHT_W'($urandom);
		else if (roll < 18)
			l = light_goal;
		else if ($urandom_range(99) < light_low_pct)
			l = LIGHT_W'(light_goal - $urandom_range(40, 1));
		else
			l = LIGHT_W'(light_goal + $urandom_range(40, 1));
		roll = $urandom_range(99);
		if (roll < 4)
			stamp = $urandom;
		else if (roll < 12)
			stamp = steer_mark + span + $urandom_range(2) - 1;
		else
			stamp = clock_ms + $urandom_range(span / 75 + 2);
		offer(t, h, l, stamp);
	endfunction

	initial begin : stimulus
		logic en;
		logic signed [TEMP_W-1:0] tsp;
		logic [HUM_W-1:0] hsp;
		logic [LIGHT_W-1:0] tgt;
		logic [HOURS_W-1:0] hrs;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// disabled after reset: everything stays at zero
		offer(-2048, 0, 0, 0);
		offer(2047, 1023, 65535, 32'hFFFF_FFFF);
		wait_drained();

		// hysteresis edges, exact toggle threshold, level steps and floor
		apply_settings(1'b1, 0, 500, 1000, 1);
		offer(-2048, 1023, 0, 100);
		offer(0, 500, 0, 3599999);
		offer(2047, 0, 65535, 3600000);
		offer(0, 500, 0, 3600001);
		offer(-1, 501, 999, 3600002);
		offer(1, 499, 1000, 3600003);
		offer(0, 500, 1001, 3600004);
		offer(0, 500, 65535, 3600005);
		offer(0, 500, 65535, 3600006);
		offer(0, 500, 0, 7199999);
		offer(-5, 900, 0, 7200000);
		offer(-5, 900, 0, 10800000);
		offer(-5, 900, 0, 10800001);
		wait_drained();

		// frozen outputs while disabled
		apply_settings(1'b0, 0, 500, 1000, 1);
		offer(2047, 0, 65535, 0);
		offer(0, 0, 0, 32'h8000_0000);
		wait_drained();

		// zero cycle hours: toggle on every step
		apply_settings(1'b1, 0, 500, 1000, 0);
		offer(0, 500, 0, 5);
		offer(0, 500, 0, 5);
		offer(0, 500, 0, 6);
		wait_drained();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			sender_idle_pct = (p < 3) ? 19 : (p < 6) ? 77 : 0;
			receiver_idle_pct = (p < 3) ? 77 : (p < 6) ? 19 : 0;
			en = 1'b1;
			tsp = TEMP_W'($urandom_range(1650) - 400);
			hsp = HUM_W'($urandom_range(1000));
			tgt = LIGHT_W'($urandom);
			case (p)
				0: begin
					tsp = -400;
					hsp = 0;
					hrs = 1;
					light_low_pct = 90;
				end
				1: begin
					tsp = 1250;
					hsp = 1000;
					tgt = 16'hFFFF;
					hrs = 0;
					light_low_pct = 50;
				end
				2: begin
					tsp = TEMP_W'($urandom);
					hsp = HUM_W'($urandom);
					tgt = 0;
					hrs = 24;
					light_low_pct = 10;
				end
				3: begin
					en = 1'b0;
					hrs = 31;
					light_low_pct = 50;
				end
				4: begin
					tsp = -2048;
					hsp = 1023;
					hrs = 2;
					light_low_pct = 90;
					clock_ms = 32'hFFD0_0000;
				end
				5: begin
					tsp = 2047;
					hrs = 1;
					light_low_pct = 70;
				end
				6: begin
					hrs = 12;
					light_low_pct = 90;
				end
				default: begin
					hrs = HOURS_W'($urandom);
					light_low_pct = 30;
				end
			endcase
			apply_settings(en, tsp, hsp, tgt, hrs);
			repeat (PHASE_STEPS) offer_random();
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/gcc_pkg.sv
hw/rtl/gcc_climate.sv
hw/rtl/gcc_lamp.sv
hw/rtl/greenhouse_climate_controller.sv
tb/testbench.sv
